// ----- rtl/mtt3_pkg.sv -----
// Package for move_toward_target_3d: request/result structs, widths, cell-stage type.
// No dependencies.
`default_nettype none
package mtt3_pkg;
    localparam int PosW   = 32;
    localparam int StepW  = 31;
    localparam int DiffW  = 33;
    localparam int AbsW   = 32;  // |D| < 2^32 (max is 2^32-1)
    localparam int SqW    = 66;  // sum of three squares < 3*2^64
    localparam int RootW  = 35;  // floor sqrt < 2^33, kept at 35 bits as in the root search
    localparam int RootSt = 35;  // one root bit per cell
    localparam int QuoW   = 32;  // quotient <= |D|
    localparam int DivSt  = 32;  // one quotient bit per cell

    typedef struct packed {
        logic signed [PosW-1:0] now_x;
        logic signed [PosW-1:0] now_y;
        logic signed [PosW-1:0] now_z;
        logic signed [PosW-1:0] dest_x;
        logic signed [PosW-1:0] dest_y;
        logic signed [PosW-1:0] dest_z;
        logic [StepW-1:0]       step_len;
    } t_req;

    typedef struct packed {
        logic signed [PosW-1:0] out_x;
        logic signed [PosW-1:0] out_y;
        logic signed [PosW-1:0] out_z;
        logic                   arrived;
    } t_res;

    // Common payload carried along both cell chains
    typedef struct packed {
        logic signed [PosW-1:0] now_x;
        logic signed [PosW-1:0] now_y;
        logic signed [PosW-1:0] now_z;
        logic signed [PosW-1:0] dest_x;
        logic signed [PosW-1:0] dest_y;
        logic signed [PosW-1:0] dest_z;
        logic [2:0]             neg;    // sign of D per axis
        logic [AbsW-1:0]        ad_x;
        logic [AbsW-1:0]        ad_y;
        logic [AbsW-1:0]        ad_z;
        logic [StepW-1:0]       step;
    } t_ctx;

    // Root cell state: remainder and partial root (restoring bitwise sqrt)
    typedef struct packed {
        logic         vld;
        t_ctx         ctx;
        logic [SqW:0] rem;     // sum with consumed pairs removed
        logic [RootW-1:0] root;
    } t_rcell;

    // Divide cell state: three dividends shifted through, partial remainders
    typedef struct packed {
        logic            vld;
        t_ctx            ctx;
        logic            arr;
        logic [RootW-1:0] len;
        logic [62:0]     nx;   // products shifted left per step
        logic [62:0]     ny;
        logic [62:0]     nz;
        logic [RootW:0]  rx;
        logic [RootW:0]  ry;
        logic [RootW:0]  rz;
        logic [QuoW-1:0] qx;
        logic [QuoW-1:0] qy;
        logic [QuoW-1:0] qz;
    } t_dcell;
endpackage
`default_nettype wire

// ----- rtl/mtt3_root_cell.sv -----
// One cell of the square-root chain: decides one root bit per cycle.
// Depends on mtt3_pkg.
`default_nettype none
module mtt3_root_cell (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [5:0]       i_bit,
    input  wire mtt3_pkg::t_rcell i_cell,
    output mtt3_pkg::t_rcell      o_cell
);
    import mtt3_pkg::*;
    t_rcell r_cell, n_cell;
    logic [SqW+2:0] trial;  // wide enough for 1 << 2*bit at the top bit

    // remainder method: trial = (root << (bit+1)) | (1 << 2*bit), as root holds bits above
    always_comb begin
        n_cell = i_cell;
        trial  = ({{(SqW+3-RootW){1'b0}}, i_cell.root} << (i_bit + 6'd1))
                 | ({{(SqW+2){1'b0}}, 1'b1} << {i_bit, 1'b0});
        if ({2'b00, i_cell.rem} >= trial) begin
            n_cell.rem  = i_cell.rem - trial[SqW:0];
            n_cell.root = i_cell.root | (RootW'(1) << i_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else begin
            r_cell.vld <= n_cell.vld;
        end
        r_cell.ctx  <= n_cell.ctx;
        r_cell.rem  <= n_cell.rem;
        r_cell.root <= n_cell.root;
    end
    assign o_cell = r_cell;
endmodule
`default_nettype wire

// ----- rtl/mtt3_div_cell.sv -----
// One cell of the divide chain: one quotient bit for each axis per cycle.
// Depends on mtt3_pkg.
`default_nettype none
module mtt3_div_cell (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire mtt3_pkg::t_dcell i_cell,
    output mtt3_pkg::t_dcell      o_cell
);
    import mtt3_pkg::*;
    t_dcell r_cell, n_cell;
    logic [RootW:0] tx, ty, tz;

    // restoring division step; dividend high bit shifts into remainder
    always_comb begin
        n_cell = i_cell;
        tx = {i_cell.rx[RootW-1:0], i_cell.nx[62]};
        ty = {i_cell.ry[RootW-1:0], i_cell.ny[62]};
        tz = {i_cell.rz[RootW-1:0], i_cell.nz[62]};
        n_cell.nx = {i_cell.nx[61:0], 1'b0};
        n_cell.ny = {i_cell.ny[61:0], 1'b0};
        n_cell.nz = {i_cell.nz[61:0], 1'b0};
        n_cell.qx = {i_cell.qx[QuoW-2:0], tx >= {1'b0, i_cell.len}};
        n_cell.qy = {i_cell.qy[QuoW-2:0], ty >= {1'b0, i_cell.len}};
        n_cell.qz = {i_cell.qz[QuoW-2:0], tz >= {1'b0, i_cell.len}};
        n_cell.rx = (tx >= {1'b0, i_cell.len}) ? tx - {1'b0, i_cell.len} : tx;
        n_cell.ry = (ty >= {1'b0, i_cell.len}) ? ty - {1'b0, i_cell.len} : ty;
        n_cell.rz = (tz >= {1'b0, i_cell.len}) ? tz - {1'b0, i_cell.len} : tz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else begin
            r_cell.vld <= n_cell.vld;
        end
        r_cell.ctx <= n_cell.ctx;
        r_cell.arr <= n_cell.arr;
        r_cell.len <= n_cell.len;
        r_cell.nx  <= n_cell.nx;
        r_cell.ny  <= n_cell.ny;
        r_cell.nz  <= n_cell.nz;
        r_cell.rx  <= n_cell.rx;
        r_cell.ry  <= n_cell.ry;
        r_cell.rz  <= n_cell.rz;
        r_cell.qx  <= n_cell.qx;
        r_cell.qy  <= n_cell.qy;
        r_cell.qz  <= n_cell.qz;
    end
    assign o_cell = r_cell;
endmodule
`default_nettype wire

// ----- rtl/move_toward_target_3d.sv -----
// Top level of move_toward_target_3d: front-end squares, root chain, divide chain.
// Depends on mtt3_pkg, mtt3_root_cell, mtt3_div_cell.
//
// channel | ports                       | handshake
// request | i_start, i_req, o_busy      | taken when i_start && !o_busy
// result  | o_done, o_res               | one-cycle strobe, no stall
//
// One request per cycle; a request passes stage A, stage B, the root cells, stage C,
// the divide cells and the output register, one root bit per root cell and one quotient bit per divide cell.
// o_busy is always low. Reset clears all valid bits; payload is not reset.
`default_nettype none
module move_toward_target_3d (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire mtt3_pkg::t_req i_req,
    output logic                o_busy,
    output logic                o_done,
    output mtt3_pkg::t_res      o_res
);
    import mtt3_pkg::*;

    // stage A: differences and magnitudes
    logic r_va;
    t_ctx r_ctx_a;
    logic signed [DiffW-1:0] dx, dy, dz;
    always_comb begin
        dx = DiffW'(i_req.dest_x) - DiffW'(i_req.now_x);
        dy = DiffW'(i_req.dest_y) - DiffW'(i_req.now_y);
        dz = DiffW'(i_req.dest_z) - DiffW'(i_req.now_z);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else begin
            r_va <= i_start;
        end
        r_ctx_a.now_x  <= i_req.now_x;
        r_ctx_a.now_y  <= i_req.now_y;
        r_ctx_a.now_z  <= i_req.now_z;
        r_ctx_a.dest_x <= i_req.dest_x;
        r_ctx_a.dest_y <= i_req.dest_y;
        r_ctx_a.dest_z <= i_req.dest_z;
        r_ctx_a.neg    <= {dz[DiffW-1], dy[DiffW-1], dx[DiffW-1]};
        r_ctx_a.ad_x   <= AbsW'(dx[DiffW-1] ? -dx : dx);
        r_ctx_a.ad_y   <= AbsW'(dy[DiffW-1] ? -dy : dy);
        r_ctx_a.ad_z   <= AbsW'(dz[DiffW-1] ? -dz : dz);
        r_ctx_a.step   <= i_req.step_len;
    end

    // stage B: three squares, then sum
    logic r_vb;
    t_ctx r_ctx_b;
    logic [63:0] r_sx, r_sy, r_sz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else begin
            r_vb <= r_va;
        end
        r_ctx_b <= r_ctx_a;
        r_sx <= 64'(r_ctx_a.ad_x) * 64'(r_ctx_a.ad_x);
        r_sy <= 64'(r_ctx_a.ad_y) * 64'(r_ctx_a.ad_y);
        r_sz <= 64'(r_ctx_a.ad_z) * 64'(r_ctx_a.ad_z);
    end

    // root chain, cell k decides root bit RootSt-1-k
    t_rcell rc [RootSt+1];
    always_comb begin
        rc[0].vld  = r_vb;
        rc[0].ctx  = r_ctx_b;
        rc[0].rem  = (SqW+1)'(r_sx) + (SqW+1)'(r_sy) + (SqW+1)'(r_sz);
        rc[0].root = '0;
    end
    for (genvar k = 0; k < RootSt; k++) begin : g_root
        mtt3_root_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_bit  (6'(RootSt - 1 - k)),
            .i_cell (rc[k]),
            .o_cell (rc[k+1])
        );
    end

    // stage C: arrival compare and products |D|*step
    logic r_vc;
    t_ctx r_ctx_c;
    logic r_arr_c;
    logic [RootW-1:0] r_len_c;
    logic [62:0] r_px, r_py, r_pz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else begin
            r_vc <= rc[RootSt].vld;
        end
        r_ctx_c <= rc[RootSt].ctx;
        r_len_c <= rc[RootSt].root;
        r_arr_c <= rc[RootSt].root <= RootW'(rc[RootSt].ctx.step);
        r_px <= 63'(rc[RootSt].ctx.ad_x) * 63'(rc[RootSt].ctx.step);
        r_py <= 63'(rc[RootSt].ctx.ad_y) * 63'(rc[RootSt].ctx.step);
        r_pz <= 63'(rc[RootSt].ctx.ad_z) * 63'(rc[RootSt].ctx.step);
    end

    // divide chain; quotient < 2^32, so the top 31 dividend bits seed the remainder
    t_dcell dc [DivSt+1];
    always_comb begin
        dc[0].vld = r_vc;
        dc[0].ctx = r_ctx_c;
        dc[0].arr = r_arr_c;
        dc[0].len = r_len_c;
        dc[0].rx  = (RootW+1)'(r_px[62:32]);
        dc[0].ry  = (RootW+1)'(r_py[62:32]);
        dc[0].rz  = (RootW+1)'(r_pz[62:32]);
        dc[0].nx  = {r_px[31:0], 31'd0};
        dc[0].ny  = {r_py[31:0], 31'd0};
        dc[0].nz  = {r_pz[31:0], 31'd0};
        dc[0].qx  = '0;
        dc[0].qy  = '0;
        dc[0].qz  = '0;
    end
    for (genvar k = 0; k < DivSt; k++) begin : g_div
        mtt3_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_cell (dc[k]),
            .o_cell (dc[k+1])
        );
    end

    // output: destination on arrival, else now +/- quotient
    t_dcell fin;
    t_res   n_res;
    assign fin = dc[DivSt];
    always_comb begin
        if (fin.arr) begin
            n_res.out_x = fin.ctx.dest_x;
            n_res.out_y = fin.ctx.dest_y;
            n_res.out_z = fin.ctx.dest_z;
        end else begin
            n_res.out_x = fin.ctx.neg[0] ? fin.ctx.now_x - fin.qx : fin.ctx.now_x + fin.qx;
            n_res.out_y = fin.ctx.neg[1] ? fin.ctx.now_y - fin.qy : fin.ctx.now_y + fin.qy;
            n_res.out_z = fin.ctx.neg[2] ? fin.ctx.now_z - fin.qz : fin.ctx.now_z + fin.qz;
        end
        n_res.arrived = fin.arr;
    end

    logic r_done;
    t_res r_res;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= fin.vld;
        end
        r_res <= n_res;
    end
    assign o_done = r_done;
    assign o_res  = r_res;
    assign o_busy = 1'b0;

`ifndef SYNTHESIS
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vc |-> ##(DivSt+1) o_done) else $error("result lost in divide chain");
    a_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vb |-> ##(RootSt+1) r_vc) else $error("result lost in root chain");
    a_arr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_res.arrived |-> $past(fin.arr)) else $error("arrived mismatch");
`endif
endmodule
`default_nettype wire
